// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the adjacency marker RTL.
// Each macro wraps a concurrent assertion on clk_i, disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication property on the rising clock edge.
`define ANM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition holds on every clock edge outside reset.
`define ANM_ASSERT_ALWAYS(label, cond, msg) \
  `ANM_ASSERT(label, 1'b1 |-> (cond), msg)

`endif

// ===== hdl/anm_pkg.sv =====
// Package for the adjacency neighbourhood marker: sizes, request codes,
// register indexes and the controller state type. No dependencies.
package anm_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int MAX_DEGREE   = 256;

  localparam int VTX_W       = 8;                        // vertex field width
  localparam int CFG_W       = 9;                        // configuration register width
  localparam int DEG_W       = $clog2(MAX_DEGREE + 1);   // degree counter width
  localparam int DEG_IDX_W   = $clog2(MAX_DEGREE);       // slot index within one list
  localparam int VIDX_W      = $clog2(MAX_VERTICES);     // vertex index into the stores
  localparam int STORE_AW    = VIDX_W + DEG_IDX_W;
  localparam int STORE_DEPTH = MAX_VERTICES * MAX_DEGREE;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_MARK   = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  typedef enum logic {
    REG_VERTEX_COUNT = 1'b0,
    REG_DEGREE_LIMIT = 1'b1
  } reg_idx_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_WR2,
    S_MARK,
    S_DONE
  } state_e;

endpackage

// ===== hdl/adjacency_neighbourhood_marker_core.sv =====
// Top level of the adjacency neighbourhood marker: controller, degree and
// neighbour memories, visited bitmap and result register.
// Depends on anm_pkg and assert_macros.svh.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+-------------------------------------
//  request   | in        | in_valid_i / in_ready_o    | req_type_i vertex_i neighbour_i directed_i
//  result    | out       | out_valid_o / out_ready_i  | marked_o rejected_o
//  config    | in        | cfg_we_i (no wait)         | cfg_idx_i cfg_wdata_i
//
// A query, a directed insert, a rejected request or an unused request code reads
// the degree memory when it is accepted in S_IDLE and decides and writes back in
// S_READ. An undirected insert also passes through S_WR2, since the degree and
// neighbour memories have one write port each. A mark walks its list in S_MARK,
// reading one neighbour per cycle from the neighbour memory. Reset clears the
// degree valid bits and the visited bitmap at once; there is no clearing pass.
// A result waiting in a full output register stalls completion of the next one.
`include "assert_macros.svh"

module adjacency_neighbourhood_marker_core
  import anm_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  // Request channel.
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           req_type_i,
  input  logic [VTX_W-1:0]     vertex_i,
  input  logic [VTX_W-1:0]     neighbour_i,
  input  logic                 directed_i,
  // Result channel.
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 marked_o,
  output logic                 rejected_o,
  // Configuration write port.
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  // Configuration registers.
  logic [CFG_W-1:0] vertex_count_q, degree_limit_q;

  // Latched request.
  logic [1:0]       req_q;
  logic [VTX_W-1:0] v_q, n_q;
  logic             dir_q;

  // Controller state.
  state_e           state_q, state_d;
  logic [DEG_W-1:0] degn_q, degn_d;       // degree of the second list of an undirected insert
  logic [DEG_W-1:0] walk_len_q, walk_len_d;
  logic [DEG_W-1:0] rd_idx_q, rd_idx_d;   // next list slot to read during a mark

  // Result holding and output registers.
  logic res_marked_q, res_rej_q;
  logic out_valid_q, out_marked_q, out_rej_q;

  // Degree memory with one valid bit per vertex; an invalid entry reads as zero.
  logic [DEG_W-1:0]        deg_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] deg_vld_q;
  logic [DEG_W-1:0]        deg_rd_a_q, deg_rd_b_q;
  logic                    deg_we;
  logic [VIDX_W-1:0]       deg_waddr;
  logic [DEG_W-1:0]        deg_wdata;

  // Neighbour memory, one row of MAX_DEGREE slots per vertex.
  logic [VTX_W-1:0]    st_mem [STORE_DEPTH];
  logic [VTX_W-1:0]    st_rdata_q;
  logic                st_we, st_re;
  logic [STORE_AW-1:0] st_waddr, st_raddr;
  logic [VTX_W-1:0]    st_wdata;

  // Visited bitmap, cleared by reset.
  logic [MAX_VERTICES-1:0] visited_q;
  logic                    vis_set_v, vis_set_walk;

  // Completion and decision signals.
  logic             in_acc, out_free;
  logic             done, done_marked, done_rej;
  logic             out_load, res_load, out_load_marked, out_load_rej;
  logic [CFG_W-1:0] cnt_eff, lim_eff;
  logic [DEG_W-1:0] deg_v, deg_n;
  logic [DEG_W:0]   deg_v1, deg_v2, deg_n1, lim_ext;
  logic             v_bad, n_bad, list_full;

  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Effective register values are clamped to the store sizes.
  assign cnt_eff = (vertex_count_q < CFG_W'(MAX_VERTICES)) ? vertex_count_q
                                                           : CFG_W'(MAX_VERTICES);
  assign lim_eff = (degree_limit_q < CFG_W'(MAX_DEGREE)) ? degree_limit_q
                                                         : CFG_W'(MAX_DEGREE);

  // The degree reads were issued when the request was accepted; v_q and n_q
  // select the matching valid bits, which cannot have changed since.
  assign deg_v   = deg_vld_q[v_q] ? deg_rd_a_q : '0;
  assign deg_n   = deg_vld_q[n_q] ? deg_rd_b_q : '0;
  assign deg_v1  = {1'b0, deg_v} + (DEG_W + 1)'(1);
  assign deg_v2  = {1'b0, deg_v} + (DEG_W + 1)'(2);
  assign deg_n1  = {1'b0, deg_n} + (DEG_W + 1)'(1);
  assign lim_ext = (DEG_W + 1)'(lim_eff);

  assign v_bad = CFG_W'(v_q) >= cnt_eff;
  assign n_bad = CFG_W'(n_q) >= cnt_eff;

  // An undirected self-loop needs two free slots in the same list.
  always_comb begin
    if (dir_q) begin
      list_full = deg_v1 > lim_ext;
    end else if (v_q == n_q) begin
      list_full = deg_v2 > lim_ext;
    end else begin
      list_full = (deg_v1 > lim_ext) || (deg_n1 > lim_ext);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state, memory accesses and completion.
  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    degn_d          = degn_q;
    walk_len_d      = walk_len_q;
    rd_idx_d        = rd_idx_q;
    deg_we          = 1'b0;
    deg_waddr       = v_q;
    deg_wdata       = deg_v1[DEG_W-1:0];
    st_we           = 1'b0;
    st_waddr        = {v_q, deg_v[DEG_IDX_W-1:0]};
    st_wdata        = n_q;
    st_re           = 1'b0;
    st_raddr        = {v_q, rd_idx_q[DEG_IDX_W-1:0]};
    vis_set_v       = 1'b0;
    vis_set_walk    = 1'b0;
    done            = 1'b0;
    done_marked     = 1'b0;
    done_rej        = 1'b0;
    out_load        = 1'b0;
    res_load        = 1'b0;
    out_load_marked = 1'b0;
    out_load_rej    = 1'b0;

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        case (req_q)
          REQ_INSERT: begin
            if (v_bad || n_bad || list_full) begin
              done     = 1'b1;
              done_rej = 1'b1;
            end else begin
              st_we  = 1'b1;
              deg_we = 1'b1;
              if (dir_q) begin
                done = 1'b1;
              end else begin
                // For a self-loop the second entry lands right after the first.
                degn_d  = (v_q == n_q) ? deg_v1[DEG_W-1:0] : deg_n;
                state_d = S_WR2;
              end
            end
          end
          REQ_MARK: begin
            if (v_bad) begin
              done     = 1'b1;
              done_rej = 1'b1;
            end else begin
              vis_set_v = 1'b1;
              if (deg_v == '0) begin
                done = 1'b1;
              end else begin
                st_re      = 1'b1;
                st_raddr   = {v_q, {DEG_IDX_W{1'b0}}};
                rd_idx_d   = DEG_W'(1);
                walk_len_d = deg_v;
                state_d    = S_MARK;
              end
            end
          end
          REQ_QUERY: begin
            done        = 1'b1;
            done_rej    = v_bad;
            done_marked = !v_bad && visited_q[v_q];
          end
          default: begin
            done = 1'b1;
          end
        endcase
      end
      S_WR2: begin
        st_we     = 1'b1;
        st_waddr  = {n_q, degn_q[DEG_IDX_W-1:0]};
        st_wdata  = v_q;
        deg_we    = 1'b1;
        deg_waddr = n_q;
        deg_wdata = degn_q + DEG_W'(1);
        done      = 1'b1;
      end
      S_MARK: begin
        // The slot read last cycle is consumed every cycle of the walk.
        vis_set_walk = 1'b1;
        if (rd_idx_q < walk_len_q) begin
          st_re    = 1'b1;
          rd_idx_d = rd_idx_q + DEG_W'(1);
        end else begin
          done = 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_load        = 1'b1;
          out_load_marked = res_marked_q;
          out_load_rej    = res_rej_q;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (done) begin
      if (out_free) begin
        out_load        = 1'b1;
        out_load_marked = done_marked;
        out_load_rej    = done_rej;
        state_d         = S_IDLE;
      end else begin
        res_load = 1'b1;
        state_d  = S_DONE;
      end
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= CFG_W'(MAX_VERTICES);
      degree_limit_q <= CFG_W'(MAX_DEGREE);
      out_valid_q    <= 1'b0;
      deg_vld_q      <= '0;
      visited_q      <= '0;
      rd_idx_q       <= '0;
      walk_len_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_VERTEX_COUNT: vertex_count_q <= cfg_wdata_i;
          REG_DEGREE_LIMIT: degree_limit_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (deg_we) begin
        deg_vld_q[deg_waddr] <= 1'b1;
      end
      if (vis_set_v) begin
        visited_q[v_q] <= 1'b1;
      end
      if (vis_set_walk) begin
        visited_q[st_rdata_q] <= 1'b1;
      end
      rd_idx_q   <= rd_idx_d;
      walk_len_q <= walk_len_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      req_q <= req_type_i;
      v_q   <= vertex_i;
      n_q   <= neighbour_i;
      dir_q <= directed_i;
    end
    degn_q <= degn_d;
    if (res_load) begin
      res_marked_q <= done_marked;
      res_rej_q    <= done_rej;
    end
    if (out_load) begin
      out_marked_q <= out_load_marked;
      out_rej_q    <= out_load_rej;
    end
  end

  // Degree memory: one write port, two registered read ports.
  always_ff @(posedge clk_i) begin
    if (deg_we) begin
      deg_mem[deg_waddr] <= deg_wdata;
    end
    if (in_acc) begin
      deg_rd_a_q <= deg_mem[vertex_i];
      deg_rd_b_q <= deg_mem[neighbour_i];
    end
  end

  // Neighbour memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (st_we) begin
      st_mem[st_waddr] <= st_wdata;
    end
    if (st_re) begin
      st_rdata_q <= st_mem[st_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign marked_o    = out_marked_q;
  assign rejected_o  = out_rej_q;

  `ANM_ASSERT(a_accept_reads, in_valid_i && in_ready_o |=> state_q == S_READ,
              "accepted request did not move to the degree read state")
  `ANM_ASSERT(a_deg_bound, deg_we |-> deg_wdata <= DEG_W'(MAX_DEGREE),
              "degree counter written past the list capacity")
  `ANM_ASSERT(a_walk_bound, state_q == S_MARK |-> rd_idx_q <= walk_len_q,
              "mark walk ran past the end of the list")
  `ANM_ASSERT_ALWAYS(a_result_excl, !(out_valid_o && marked_o && rejected_o),
                     "result both marked and rejected")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for adjacency_neighbourhood_marker_core: edge inserts,
// neighbourhood marks and queries, checked against an in-bench predictor.
// Depends on anm_pkg and the core RTL.
module tb_top;
  import anm_pkg::*;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES = 300;

  typedef struct packed {
    logic marked;
    logic rejected;
  } outcome_t;

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_ready_o;
  logic [1:0]       req_type_i;
  logic [VTX_W-1:0] vertex_i;
  logic [VTX_W-1:0] neighbour_i;
  logic             directed_i;
  logic             out_valid_o;
  logic             out_ready_i;
  logic             marked_o;
  logic             rejected_o;
  logic             cfg_we_i;
  logic             cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  adjacency_neighbourhood_marker_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .req_type_i  (req_type_i),
    .vertex_i    (vertex_i),
    .neighbour_i (neighbour_i),
    .directed_i  (directed_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .marked_o    (marked_o),
    .rejected_o  (rejected_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  // Predicted graph state: one list per vertex, its length, and the visited bits.
  logic [VTX_W-1:0] list_entry [MAX_VERTICES][MAX_DEGREE];
  int unsigned      list_len   [MAX_VERTICES];
  bit               visit_bit  [MAX_VERTICES];
  int unsigned      vertex_limit;
  int unsigned      degree_cap;

  outcome_t    pending_outcomes [$];
  int unsigned mismatch_count;
  int unsigned sender_idle_pct;
  int unsigned receiver_stall_pct;
  int unsigned hold_token;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic void append_entry(int unsigned v, int unsigned n);
    list_entry[v][list_len[v]] = n[VTX_W-1:0];
    list_len[v]++;
  endfunction

  // Applies one request to the predicted state and returns the result it causes.
  function automatic outcome_t adjacency_outcome(logic [1:0] kind, logic [VTX_W-1:0] v,
                                                 logic [VTX_W-1:0] n, logic one_way);
    outcome_t    res;
    int unsigned cnt;
    int unsigned lim;
    res = '0;
    cnt = (vertex_limit < MAX_VERTICES) ? vertex_limit : MAX_VERTICES;
    lim = (degree_cap < MAX_DEGREE) ? degree_cap : MAX_DEGREE;
    case (kind)
      REQ_INSERT: begin
        if (v >= cnt || n >= cnt) begin
          res.rejected = 1'b1;
        end else if (one_way) begin
          if (list_len[v] + 1 > lim) res.rejected = 1'b1;
          else append_entry(v, n);
        end else if (v == n) begin
          // An undirected self-loop lands twice in the same list.
          if (list_len[v] + 2 > lim) begin
            res.rejected = 1'b1;
          end else begin
            append_entry(v, n);
            append_entry(n, v);
          end
        end else begin
          if (list_len[v] + 1 > lim || list_len[n] + 1 > lim) begin
            res.rejected = 1'b1;
          end else begin
            append_entry(v, n);
            append_entry(n, v);
          end
        end
      end
      REQ_MARK: begin
        if (v >= cnt) begin
          res.rejected = 1'b1;
        end else begin
          // The walk covers every stored entry, whatever the current limits.
          visit_bit[v] = 1'b1;
          for (int unsigned j = 0; j < list_len[v]; j++) visit_bit[list_entry[v][j]] = 1'b1;
        end
      end
      REQ_QUERY: begin
        if (v >= cnt) res.rejected = 1'b1;
        else res.marked = visit_bit[v];
      end
      default: ;
    endcase
    return res;
  endfunction

  // Offers one request and records its predicted result once it is accepted.
  // Entered and left at a falling edge; valid stays high between back-to-back requests.
  task automatic send_request(logic [1:0] kind, logic [VTX_W-1:0] v, logic [VTX_W-1:0] n,
                              logic one_way);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    req_type_i  = kind;
    vertex_i    = v;
    neighbour_i = n;
    directed_i  = one_way;
    in_valid_i  = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    pending_outcomes.push_back(adjacency_outcome(kind, v, n, one_way));
    @(negedge clk_i);
  endtask

  // Waits until every result is back and the core has settled, then writes a register.
  task automatic write_register(reg_idx_e idx, logic [CFG_W-1:0] value);
    in_valid_i = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = value;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == REG_VERTEX_COUNT) vertex_limit = value;
    else degree_cap = value;
  endtask

  // Mostly vertices in range, often a few hot ones so that lists fill up, sometimes any.
  function automatic logic [VTX_W-1:0] pick_vertex();
    int unsigned eff;
    int unsigned r;
    eff = (vertex_limit < MAX_VERTICES) ? vertex_limit : MAX_VERTICES;
    r = $urandom_range(99);
    if (eff == 0 || r < 15) return VTX_W'($urandom_range(255));
    if (r < 55) return VTX_W'($urandom_range(((eff < 8) ? eff : 8) - 1));
    return VTX_W'($urandom_range(eff - 1));
  endfunction

  task automatic send_random_request();
    int unsigned r;
    logic [1:0]  kind;
    r = $urandom_range(99);
    if (r < 44) kind = REQ_INSERT;
    else if (r < 64) kind = REQ_MARK;
    else if (r < 95) kind = REQ_QUERY;
    else kind = REQ_UNUSED;
    send_request(kind, pick_vertex(), pick_vertex(), 1'($urandom_range(1)));
  endtask

  // Hand-picked requests: field extremes, every request code and each corner of
  // range checking, full lists, self-loops and lowered register values.
  task automatic test_directed_cases();
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    send_request(REQ_QUERY, 8'd0, 8'd0, 1'b0);
    send_request(REQ_INSERT, 8'd0, 8'd1, 1'b0);
    send_request(REQ_INSERT, 8'd2, 8'd3, 1'b1);
    send_request(REQ_MARK, 8'd0, 8'd255, 1'b1);
    send_request(REQ_QUERY, 8'd1, 8'd0, 1'b0);
    send_request(REQ_QUERY, 8'd2, 8'd0, 1'b0);
    send_request(REQ_MARK, 8'd2, 8'd0, 1'b0);
    send_request(REQ_QUERY, 8'd3, 8'd255, 1'b1);
    send_request(REQ_UNUSED, 8'd255, 8'd255, 1'b1);
    send_request(REQ_INSERT, 8'd255, 8'd254, 1'b0);
    send_request(REQ_INSERT, 8'd5, 8'd5, 1'b0);
    send_request(REQ_MARK, 8'd255, 8'd0, 1'b0);
    send_request(REQ_QUERY, 8'd254, 8'd0, 1'b0);
    send_request(REQ_MARK, 8'd5, 8'd0, 1'b0);
    send_request(REQ_QUERY, 8'd5, 8'd0, 1'b0);

    // Small graph: out-of-range vertices and lists that fill after two entries.
    write_register(REG_VERTEX_COUNT, 9'd10);
    write_register(REG_DEGREE_LIMIT, 9'd2);
    send_request(REQ_INSERT, 8'd10, 8'd0, 1'b1);
    send_request(REQ_INSERT, 8'd3, 8'd11, 1'b0);
    send_request(REQ_MARK, 8'd10, 8'd0, 1'b0);
    send_request(REQ_QUERY, 8'd200, 8'd0, 1'b0);
    send_request(REQ_INSERT, 8'd6, 8'd6, 1'b0);
    send_request(REQ_INSERT, 8'd6, 8'd7, 1'b1);
    send_request(REQ_INSERT, 8'd7, 8'd6, 1'b0);
    send_request(REQ_INSERT, 8'd8, 8'd9, 1'b1);
    send_request(REQ_INSERT, 8'd0, 8'd4, 1'b0);

    // A stored neighbour beyond a lowered count still gets marked.
    write_register(REG_VERTEX_COUNT, 9'd9);
    send_request(REQ_MARK, 8'd8, 8'd0, 1'b0);
    send_request(REQ_QUERY, 8'd9, 8'd0, 1'b0);
    write_register(REG_VERTEX_COUNT, 9'd256);
    send_request(REQ_QUERY, 8'd9, 8'd0, 1'b0);

    // A list longer than a lowered limit is walked in full.
    write_register(REG_DEGREE_LIMIT, 9'd1);
    send_request(REQ_MARK, 8'd0, 8'd0, 1'b0);
    send_request(REQ_QUERY, 8'd4, 8'd0, 1'b0);

    // Zero values reject every vertex, then every insert.
    write_register(REG_VERTEX_COUNT, 9'd0);
    send_request(REQ_QUERY, 8'd0, 8'd0, 1'b0);
    send_request(REQ_INSERT, 8'd0, 8'd0, 1'b1);
    write_register(REG_VERTEX_COUNT, 9'd256);
    write_register(REG_DEGREE_LIMIT, 9'd0);
    send_request(REQ_INSERT, 8'd20, 8'd21, 1'b1);
    send_request(REQ_MARK, 8'd20, 8'd0, 1'b0);

    // Values above the sizes saturate to them.
    write_register(REG_VERTEX_COUNT, 9'd511);
    write_register(REG_DEGREE_LIMIT, 9'd511);
    send_request(REQ_INSERT, 8'd255, 8'd0, 1'b1);
    send_request(REQ_QUERY, 8'd255, 8'd0, 1'b0);
  endtask

  // One phase of random traffic under a given register setting and idling pattern.
  task automatic test_random_traffic(int unsigned vcount, int unsigned dlimit,
                                     int unsigned idle_pct, int unsigned stall_pct,
                                     int unsigned count);
    write_register(REG_VERTEX_COUNT, CFG_W'(vcount));
    write_register(REG_DEGREE_LIMIT, CFG_W'(dlimit));
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) send_random_request();
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the
  // core fills and stalls its request channel.
  task automatic test_output_backpressure();
    write_register(REG_VERTEX_COUNT, 9'd64);
    write_register(REG_DEGREE_LIMIT, 9'd16);
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    hold_token++;
    repeat (150) send_random_request();
  endtask

  // Receiver: random stalls, plus a long hold-off each time one is asked for.
  initial begin : drive_receiver
    int unsigned hold_seen;
    int unsigned hold_left;
    hold_seen   = 0;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ready_i = 1'b0;
      end else begin
        out_ready_i = ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  // Every accepted result is compared with the oldest prediction.
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_outcomes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result: marked=%0b rejected=%0b", marked_o, rejected_o);
      end else begin
        want = pending_outcomes.pop_front();
        if (marked_o !== want.marked || rejected_o !== want.rejected) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("result mismatch: expected marked=%0b rejected=%0b, %s%0b %s%0b",
                     want.marked, want.rejected, "got marked=", marked_o,
                     "rejected=", rejected_o);
        end
      end
    end
  end

  // Ends the run when work is outstanding but nothing moves for too long.
  always @(posedge clk_i) begin : watchdog
    int unsigned quiet_cycles;
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        !(in_valid_i || pending_outcomes.size() != 0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst_ni             = 1'b0;
    in_valid_i         = 1'b0;
    req_type_i         = REQ_INSERT;
    vertex_i           = '0;
    neighbour_i        = '0;
    directed_i         = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = REG_VERTEX_COUNT;
    cfg_wdata_i        = '0;
    mismatch_count     = 0;
    hold_token         = 0;
    sender_idle_pct    = 0;
    receiver_stall_pct = 0;
    vertex_limit       = 256;
    degree_cap         = 256;
    for (int i = 0; i < MAX_VERTICES; i++) begin
      list_len[i]  = 0;
      visit_bit[i] = 1'b0;
    end
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_directed_cases();
    test_random_traffic(256, 256, 0, 0, 300);
    test_random_traffic(16, 4, 69, 0, 250);
    test_random_traffic(100, 511, 0, 69, 250);
    test_random_traffic(1, 1, 6, 6, 150);
    test_output_backpressure();
    test_random_traffic(255, 3, 69, 0, 200);
    test_random_traffic(32, 256, 0, 69, 250);
    test_random_traffic(511, 2, 6, 6, 100);

    in_valid_i = 1'b0;
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== adjacency_neighbourhood_marker_core.f =====
+incdir+hdl
hdl/anm_pkg.sv
hdl/adjacency_neighbourhood_marker_core.sv
bench/tb_top.sv
